// File: src/nfa_pkg.sv
// nfa_pkg: shared types, constants and the tanh table function for the neuron
// forward activation block. Depends on nothing; used by every file in src.
`timescale 1ns / 1ps
`default_nettype none

package nfa_pkg;

    localparam int ACC_W   = 40;   // Q16.24 accumulator
    localparam int PROD_W  = 32;   // Q8.24 product of two Q4.12 values
    localparam int Q_W     = 16;   // Q4.12
    localparam int MODE_W  = 2;

    // activation codes; the unused code behaves as tanh
    localparam logic [MODE_W-1:0] MODE_IDENTITY = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RELU     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TANH     = 2'd2;

    // tanh table over |x| in [0, 8); depth must be a power of two
    localparam int TANH_DEPTH = 256;
    localparam int TANH_IDX_W = $clog2(TANH_DEPTH);
    localparam int TANH_TOP   = 27;                 // 8.0 in Q8.24 is 2^27
    localparam int TANH_SHIFT = TANH_TOP - TANH_IDX_W;
    localparam int TANH_W     = 13;                 // holds 0 .. 4096
    localparam logic [TANH_W-1:0] TANH_ONE = 13'd4096;

    localparam logic [63:0] Q31_ONE         = 64'h0000_0000_8000_0000;
    localparam logic [63:0] EXP_NEG_ONE_Q31 = 64'd790015084;

    typedef struct packed {
        logic signed [Q_W-1:0] activation_in;
        logic signed [Q_W-1:0] weight_in;
        logic                  last;
    } nfa_in_t;

    typedef struct packed {
        logic signed [Q_W-1:0] neuron_out;
        logic                  saturated;
    } nfa_out_t;

    // finished sum handed from the mac stage to the activation stage
    typedef struct packed {
        logic                    valid;
        logic signed [ACC_W-1:0] acc;
    } nfa_sum_t;

    // shift-subtract long division for the table constants
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d})
            begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // tanh(16 * idx / TANH_DEPTH / 2) in Q4.12, built from exp(-2x) in Q1.31;
    // only ever evaluated into localparams
    function automatic logic [TANH_W-1:0] tanh_entry(input int unsigned idx);
        logic [63:0]        scaled;
        logic [63:0]        whole;
        logic [63:0]        num;
        logic [63:0]        term;
        logic [63:0]        e;
        logic [63:0]        numr;
        logic [63:0]        den;
        logic [63:0]        q;
        logic signed [63:0] sum;
        scaled = 64'(16 * idx);
        whole  = scaled >> TANH_IDX_W;
        num    = scaled & 64'(TANH_DEPTH - 1);
        sum    = $signed(Q31_ONE);
        term   = Q31_ONE;
        for (int k = 1; k <= 24; k++)
        begin
            term = udiv64(term * num, 64'(TANH_DEPTH) * 64'(k));
            if ((k & 1) != 0)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        e = (sum < 0) ? 64'd0 : $unsigned(sum);
        for (int k = 0; k < 16; k++)
        begin
            if (64'(k) < whole)
                e = (e * EXP_NEG_ONE_Q31 + (Q31_ONE >> 1)) >> 31;
        end
        if (e > Q31_ONE)
            e = Q31_ONE;
        numr = (Q31_ONE - e) * 64'd4096;
        den  = Q31_ONE + e;
        q    = udiv64(numr + (den >> 1), den);
        return q[TANH_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: src/neuron_forward_activation.sv
// neuron_forward_activation: top level with the activation mode register,
// the mac pipeline and the activation stage. Depends on nfa_pkg, nfa_mac, nfa_act.
//
//   channel  | direction | handshake          | word
//   ---------+-----------+--------------------+------------------------------------
//   in       | in        | in_valid/in_stall  | nfa_in_t: activation_in, weight_in, last
//   out      | out       | out_valid/out_stall| nfa_out_t: neuron_out, saturated
//   cfg      | in        | cfg_valid/cfg_ready| 2-bit activation mode (ready always high)
//
// one word accepted per cycle while in_stall is low; four register stages
// (input, product, sum, output) carry a last word's result through to out.
// words without last make no result; the accumulator clears with each last word.
// reset: accumulator zero, mode tanh, all stages empty.
// a stalled output fills the stages behind it one by one before in_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module neuron_forward_activation
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire nfa_pkg::nfa_in_t              in_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output nfa_pkg::nfa_out_t                  out_data,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [nfa_pkg::MODE_W-1:0]    cfg_data
);

    logic [nfa_pkg::MODE_W-1:0] mode_reg;
    logic [nfa_pkg::MODE_W-1:0] mode_next;
    nfa_pkg::nfa_sum_t          sum;
    logic                       sum_ready;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        mode_next = mode_reg;
        if (cfg_valid && cfg_ready)
            mode_next = cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= nfa_pkg::MODE_TANH;
        else
            mode_reg <= mode_next;
    end

    nfa_mac u_mac
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .sum       (sum),
        .sum_ready (sum_ready)
    );

    nfa_act u_act
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .sum       (sum),
        .sum_ready (sum_ready),
        .mode      (mode_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // input only backs up once every stage is full behind a stalled output
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("in_stall without a stalled output");

    // tanh never clips
    a_tanh_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && mode_reg != nfa_pkg::MODE_IDENTITY && mode_reg != nfa_pkg::MODE_RELU)
        |-> !out_data.saturated)
        else $error("saturated set in tanh mode");

    // tanh magnitude stays within one
    a_tanh_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && mode_reg != nfa_pkg::MODE_IDENTITY && mode_reg != nfa_pkg::MODE_RELU)
        |-> (out_data.neuron_out <= 16'sd4096 && out_data.neuron_out >= -16'sd4096))
        else $error("tanh output out of range");

    // relu never goes negative
    a_relu_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && mode_reg == nfa_pkg::MODE_RELU) |-> !out_data.neuron_out[15])
        else $error("negative relu output");

endmodule

`default_nettype wire

// File: src/nfa_mac.sv
// nfa_mac: input register, product register and the 40-bit accumulator.
// Depends on nfa_pkg for the word and sum types.
`timescale 1ns / 1ps
`default_nettype none

module nfa_mac
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire nfa_pkg::nfa_in_t in_data,
    output nfa_pkg::nfa_sum_t    sum,
    input  wire logic            sum_ready
);

    logic                                 in_v_reg;
    logic                                 in_v_next;
    nfa_pkg::nfa_in_t                     in_reg;
    logic                                 prod_v_reg;
    logic                                 prod_v_next;
    logic signed [nfa_pkg::PROD_W-1:0]    prod_reg;
    logic                                 last_reg;
    logic signed [nfa_pkg::ACC_W-1:0]     acc_reg;
    logic signed [nfa_pkg::ACC_W-1:0]     acc_next;
    logic signed [nfa_pkg::ACC_W-1:0]     acc_sum;
    logic                                 load_in;
    logic                                 move_in;
    logic                                 move_prod;
    logic                                 ready_in;
    logic                                 ready_prod;

    // a last word only leaves the product stage when the sum can be taken
    assign move_prod  = prod_v_reg && (!last_reg || sum_ready);
    assign ready_prod = !prod_v_reg || move_prod;
    assign move_in    = in_v_reg && ready_prod;
    assign ready_in   = !in_v_reg || move_in;
    assign load_in    = in_valid && ready_in;
    assign in_stall   = !ready_in;

    assign acc_sum = acc_reg + {{(nfa_pkg::ACC_W - nfa_pkg::PROD_W){prod_reg[nfa_pkg::PROD_W-1]}},
                                prod_reg};

    assign sum.valid = prod_v_reg && last_reg;
    assign sum.acc   = acc_sum;

    always_comb
    begin
        in_v_next = in_v_reg;
        if (load_in)
            in_v_next = 1'b1;
        else if (move_in)
            in_v_next = 1'b0;

        prod_v_next = prod_v_reg;
        if (move_in)
            prod_v_next = 1'b1;
        else if (move_prod)
            prod_v_next = 1'b0;

        acc_next = acc_reg;
        if (move_prod)
            acc_next = last_reg ? '0 : acc_sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg   <= 1'b0;
            prod_v_reg <= 1'b0;
            acc_reg    <= '0;
        end
        else
        begin
            in_v_reg   <= in_v_next;
            prod_v_reg <= prod_v_next;
            acc_reg    <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in)
            in_reg <= in_data;
        if (move_in)
        begin
            prod_reg <= in_reg.activation_in * in_reg.weight_in;
            last_reg <= in_reg.last;
        end
    end

endmodule

`default_nettype wire

// File: src/nfa_act.sv
// nfa_act: sum register, rounding / relu / tanh lookup with saturation, and
// the output register. Depends on nfa_pkg for types, codes and the tanh table.
`timescale 1ns / 1ps
`default_nettype none

module nfa_act
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire nfa_pkg::nfa_sum_t             sum,
    output logic                               sum_ready,
    input  wire logic [nfa_pkg::MODE_W-1:0]    mode,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output nfa_pkg::nfa_out_t                  out_data
);

    logic                                  sum_v_reg;
    logic                                  sum_v_next;
    logic signed [nfa_pkg::ACC_W-1:0]      sum_reg;
    logic                                  out_v_reg;
    logic                                  out_v_next;
    nfa_pkg::nfa_out_t                     out_reg;
    nfa_pkg::nfa_out_t                     result;
    logic                                  move_sum;
    logic                                  ready_out;
    logic                                  load_sum;

    logic signed [nfa_pkg::ACC_W:0]        rnd_full;
    logic signed [nfa_pkg::ACC_W-12:0]     rnd;
    logic signed [nfa_pkg::Q_W-1:0]        lin_val;
    logic                                  lin_sat;

    logic [nfa_pkg::TANH_W-1:0]            tanh_rom [nfa_pkg::TANH_DEPTH];
    logic [nfa_pkg::ACC_W-1:0]             mag;
    logic                                  over;
    logic [nfa_pkg::TANH_IDX_W-1:0]        tanh_idx;
    logic [nfa_pkg::TANH_W-1:0]            tanh_mag;
    logic signed [nfa_pkg::Q_W-1:0]        tanh_val;

    for (genvar gi = 0; gi < nfa_pkg::TANH_DEPTH; gi++)
    begin : g_rom
        localparam logic [nfa_pkg::TANH_W-1:0] ENTRY = nfa_pkg::tanh_entry(gi);
        assign tanh_rom[gi] = ENTRY;
    end

    assign ready_out = !out_v_reg || !out_stall;
    assign move_sum  = sum_v_reg && ready_out;
    assign sum_ready = !sum_v_reg || move_sum;
    assign load_sum  = sum.valid && sum_ready;

    // round half up to Q4.12
    assign rnd_full = {sum_reg[nfa_pkg::ACC_W-1], sum_reg} + 41'sd2048;
    assign rnd      = rnd_full[nfa_pkg::ACC_W:12];

    always_comb
    begin
        lin_val = rnd[nfa_pkg::Q_W-1:0];
        lin_sat = 1'b0;
        if (mode == nfa_pkg::MODE_RELU && rnd < 0)
            lin_val = '0;
        else if (rnd > 29'sd32767)
        begin
            lin_val = 16'sh7FFF;
            lin_sat = 1'b1;
        end
        else if (rnd < -29'sd32768)
        begin
            lin_val = 16'sh8000;
            lin_sat = 1'b1;
        end
    end

    // |sum| of 8.0 or more reads as exactly one
    assign mag      = sum_reg[nfa_pkg::ACC_W-1] ? nfa_pkg::ACC_W'(-sum_reg) : sum_reg;
    assign over     = |mag[nfa_pkg::ACC_W-1:nfa_pkg::TANH_TOP];
    assign tanh_idx = mag[nfa_pkg::TANH_SHIFT +: nfa_pkg::TANH_IDX_W];
    assign tanh_mag = over ? nfa_pkg::TANH_ONE : tanh_rom[tanh_idx];
    assign tanh_val = sum_reg[nfa_pkg::ACC_W-1] ? -$signed({3'b000, tanh_mag})
                                                : $signed({3'b000, tanh_mag});

    always_comb
    begin
        if (mode == nfa_pkg::MODE_IDENTITY || mode == nfa_pkg::MODE_RELU)
        begin
            result.neuron_out = lin_val;
            result.saturated  = lin_sat;
        end
        else
        begin
            result.neuron_out = tanh_val;
            result.saturated  = 1'b0;
        end
    end

    always_comb
    begin
        sum_v_next = sum_v_reg;
        if (load_sum)
            sum_v_next = 1'b1;
        else if (move_sum)
            sum_v_next = 1'b0;

        out_v_next = out_v_reg;
        if (move_sum)
            out_v_next = 1'b1;
        else if (!out_stall)
            out_v_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            sum_v_reg <= sum_v_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_sum)
            sum_reg <= sum.acc;
        if (move_sum)
            out_reg <= result;
    end

    assign out_valid = out_v_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire
